FILE: hdl/mmu_block_and_page_translation_assert.svh
// Assertion macros shared by the translation block.
`ifndef MMU_BLOCK_AND_PAGE_TRANSLATION_ASSERT_SVH
`define MMU_BLOCK_AND_PAGE_TRANSLATION_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MMU_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Implication checked in the cycle after the condition.
`define MMU_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

FILE: hdl/mmu_pkg.sv
// Shared constants and a helper function of the translation block.
package mmu_pkg;
    localparam int TABLE_ENTRIES = 4096;
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int BAT_PER_SIDE = 4;
    localparam int BAT_N = 2 * BAT_PER_SIDE;
    localparam int BW = $clog2(BAT_N);
    localparam int BSW = (BAT_PER_SIDE > 1) ? $clog2(BAT_PER_SIDE) : 1;
    localparam int ENTRIES_PER_GROUP = 8;

    localparam logic [2:0] OP_XLATE = 3'd0;
    localparam logic [2:0] OP_BATU = 3'd1;
    localparam logic [2:0] OP_BATL = 3'd2;
    localparam logic [2:0] OP_SEG = 3'd3;
    localparam logic [2:0] OP_PTE = 3'd4;

    localparam logic [1:0] FK_NONE = 2'd0;
    localparam logic [1:0] FK_PROT = 2'd1;
    localparam logic [1:0] FK_PAGE = 2'd2;
    localparam logic [1:0] FK_DS = 2'd3;

    localparam logic [1:0] EK_NONE = 2'd0;
    localparam logic [1:0] EK_ISI = 2'd1;
    localparam logic [1:0] EK_DSI = 2'd2;

    localparam logic [31:0] ST_PAGE = 32'h4000_0000;
    localparam logic [31:0] ST_PROT = 32'h0800_0000;
    localparam logic [31:0] ST_STORE = 32'h0200_0000;

    function automatic logic denied(input logic [1:0] pp, input logic store);
        denied = store ? (pp != 2'd2) : (pp == 2'd0);
    endfunction
endpackage

FILE: hdl/mmu_block_and_page_translation.sv
// Top level of the block and page address translation unit.
// Usage: an item is issued by raising start with the payload while busy is low.
// Write items (BAT words, segment registers, page-table entries) go straight to the done state.
// A translate item scans the BAT entries of its side one a cycle, reads the segment
// register, then reads up to sixteen page-table entries, one per cycle, with a priming read
// at the start of each group, from a single synchronous memory with a registered read port.
// Each item yields one result beat, shown for one cycle with o_valid high; the
// receiver cannot stall, and busy falls in the cycle that shows the beat.
// The table base and hash mask register is written through the APB port; the user must write
// it only while the block is idle, as the block has no guard for this; pready is always high.
// After reset the block sweeps all TABLE_ENTRIES entries (4096 by default) of the page-table
// memory to zero, one entry per cycle, holding busy high meanwhile.
// BAT words and segment registers clear at once with reset.
module mmu_block_and_page_translation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [11:0] i_table_index,
    input  logic [31:0] i_effective_address,
    input  logic [63:0] i_write_data,
    input  logic [2:0]  i_access_flags,
    input  logic        i_problem_state,
    output logic        o_valid,
    output logic [31:0] o_physical_address,
    output logic        o_translated,
    output logic [1:0]  o_fault_kind,
    output logic [1:0]  o_exception_kind,
    output logic [31:0] o_fault_address,
    output logic [31:0] o_fault_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mmu_pkg::*;
    `include "mmu_block_and_page_translation_assert.svh"

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_BAT = 3'd2;
    localparam logic [2:0] S_SEG = 3'd3;
    localparam logic [2:0] S_PTE = 3'd4;
    localparam logic [2:0] S_FAULT = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [63:0] r_mem [TABLE_ENTRIES];
    logic [63:0] r_rd;
    logic [31:0] r_batu [BAT_N];
    logic [31:0] r_batl [BAT_N];
    logic [31:0] r_seg [16];
    logic [31:0] r_cfg;

    logic [2:0]  r_st;
    logic [TW:0] r_clr;
    logic [2:0]  r_op;
    logic [11:0] r_idx;
    logic [31:0] r_ea;
    logic [63:0] r_wd;
    logic [2:0]  r_fl;
    logic        r_user;
    logic [BSW:0] r_bi;
    logic [3:0]  r_pi;
    logic        r_rdv;
    logic [18:0] r_hash;
    logic [31:0] r_tgt;
    logic [1:0]  r_kind;

    logic        mem_we;
    logic [TW-1:0] mem_wa, mem_ra;
    logic [63:0] mem_wd;
    logic        mem_re;

    logic [31:0] bu, bl_w, blen, bmask, seg_w, pteg, base;
    logic [BW-1:0] bsel;
    logic        code, store, quiet, accept;

    assign code = r_fl[0];
    assign store = r_fl[1];
    assign quiet = r_fl[2];
    assign busy = (r_st != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? r_cfg : 32'd0;

    assign bsel = BW'((code ? 0 : BAT_PER_SIDE) + int'(r_bi[BSW-1:0]));
    assign bu = r_batu[bsel];
    assign bl_w = r_batl[bsel];
    assign blen = bu & 32'h0000_1FFC;
    assign bmask = (~blen << 15) & 32'hFFFE_0000;
    assign seg_w = r_seg[r_ea[31:28]];
    assign pteg = (r_cfg & 32'hFFFF_0000)
        | (((r_cfg & 32'h0000_01FF) & {13'd0, r_hash[18:10]}) << 16)
        | ({22'd0, r_hash[9:0]} << 6);
    assign base = pteg >> 3;

    always_comb begin
        mem_re = (r_st == S_PTE) && (r_pi < 4'd15 || !r_rdv) ;
        mem_ra = TW'(base + {29'd0, r_rdv ? r_pi[2:0] + 3'd1 : r_pi[2:0]});
        if (r_st == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_clr[TW-1:0];
            mem_wd = 64'd0;
        end else begin
            mem_we = (r_st == S_DONE) && (r_op == OP_PTE)
                && ({20'd0, r_idx} < 32'(TABLE_ENTRIES));
            mem_wa = r_idx[TW-1:0];
            mem_wd = r_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_cfg <= '0;
            r_rdv <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k < BAT_N; k++) begin
                r_batu[k] <= '0;
                r_batl[k] <= '0;
            end
            for (int k = 0; k < 16; k++) begin
                r_seg[k] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            if (psel && penable && pwrite && paddr == 2'd0) begin
                r_cfg <= pwdata;
            end
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (TW+1)'(TABLE_ENTRIES - 1)) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op <= i_opcode;
                        r_idx <= i_table_index;
                        r_ea <= i_effective_address;
                        r_wd <= i_write_data;
                        r_fl <= i_access_flags;
                        r_user <= i_problem_state;
                        r_bi <= '0;
                        r_st <= (i_opcode == OP_XLATE) ? S_BAT : S_DONE;
                    end
                end
                S_BAT: begin
                    if ((r_user ? bu[0] : bu[1])
                        && ((r_ea & bmask) == (bu & 32'hFFFE_0000))) begin
                        if (denied(bl_w[1:0], store)) begin
                            r_kind <= FK_PROT;
                            r_st <= S_FAULT;
                        end else begin
                            o_valid <= 1'b1;
                            o_physical_address <= (bl_w & 32'hFFFE_0000)
                                | (r_ea & ((blen << 15) | 32'h0001_FFFF));
                            o_translated <= 1'b1;
                            o_fault_kind <= FK_NONE;
                            o_exception_kind <= EK_NONE;
                            o_fault_address <= '0;
                            o_fault_status <= '0;
                            r_st <= S_IDLE;
                        end
                    end else if (r_bi == (BSW+1)'(BAT_PER_SIDE - 1)) begin
                        r_st <= S_SEG;
                    end else begin
                        r_bi <= r_bi + 1'b1;
                    end
                end
                S_SEG: begin
                    r_hash <= (seg_w[18:0]) ^ {3'd0, r_ea[27:12]};
                    r_tgt <= {1'b1, seg_w[23:0], 1'b0, r_ea[27:22]};
                    r_pi <= '0;
                    r_rdv <= 1'b0;
                    if (seg_w[31]) begin
                        o_valid <= 1'b1;
                        o_physical_address <= '0;
                        o_translated <= 1'b0;
                        o_fault_kind <= FK_DS;
                        o_exception_kind <= EK_NONE;
                        o_fault_address <= '0;
                        o_fault_status <= '0;
                        r_st <= S_IDLE;
                    end else if (code && seg_w[28]) begin
                        r_kind <= FK_PROT;
                        r_st <= S_FAULT;
                    end else begin
                        r_st <= S_PTE;
                    end
                end
                S_PTE: begin
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else if (r_rd[63:32] == r_tgt) begin
                        r_rdv <= 1'b0;
                        if (denied(r_rd[1:0], store)) begin
                            r_kind <= FK_PROT;
                            r_st <= S_FAULT;
                        end else begin
                            o_valid <= 1'b1;
                            o_physical_address <= {r_rd[31:12], r_ea[11:0]};
                            o_translated <= 1'b1;
                            o_fault_kind <= FK_NONE;
                            o_exception_kind <= EK_NONE;
                            o_fault_address <= '0;
                            o_fault_status <= '0;
                            r_st <= S_IDLE;
                        end
                    end else if (r_pi == 4'd15) begin
                        r_rdv <= 1'b0;
                        r_kind <= FK_PAGE;
                        r_st <= S_FAULT;
                    end else if (r_pi == 4'd7) begin
                        r_pi <= r_pi + 1'b1;
                        r_rdv <= 1'b0;
                        r_hash <= r_hash ^ 19'h7FFFF;
                        r_tgt <= r_tgt ^ 32'h0000_0040;
                    end else begin
                        r_pi <= r_pi + 1'b1;
                    end
                end
                S_FAULT: begin
                    o_valid <= 1'b1;
                    o_physical_address <= '0;
                    o_translated <= 1'b0;
                    o_fault_kind <= r_kind;
                    o_exception_kind <= quiet ? EK_NONE : (code ? EK_ISI : EK_DSI);
                    o_fault_address <= (quiet || code) ? 32'd0 : r_ea;
                    o_fault_status <= (quiet || code) ? 32'd0
                        : (((r_kind == FK_PAGE) ? ST_PAGE : ST_PROT)
                            | (store ? ST_STORE : 32'd0));
                    r_st <= S_IDLE;
                end
                S_DONE: begin
                    case (r_op)
                        OP_BATU: if ({9'd0, r_idx} < 21'(BAT_N)) r_batu[r_idx[BW-1:0]] <= r_wd[31:0];
                        OP_BATL: if ({9'd0, r_idx} < 21'(BAT_N)) r_batl[r_idx[BW-1:0]] <= r_wd[31:0];
                        OP_SEG:  if (r_idx < 12'd16) r_seg[r_idx[3:0]] <= r_wd[31:0];
                        default: ;
                    endcase
                    o_valid <= 1'b1;
                    o_physical_address <= '0;
                    o_translated <= (r_op <= OP_PTE);
                    o_fault_kind <= FK_NONE;
                    o_exception_kind <= EK_NONE;
                    o_fault_address <= '0;
                    o_fault_status <= '0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `MMU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "busy not raised after accept")
    `MMU_ASSERT_IMPL(a_ok_clean, i_clk, i_rst_n, o_valid && o_translated, o_fault_kind == FK_NONE && o_exception_kind == EK_NONE, "success beat carries fault")
    `MMU_ASSERT_IMPL(a_no_beat_clr, i_clk, i_rst_n, r_st == S_CLR, !o_valid, "result during clearing")
    `MMU_ASSERT_NEXT(a_beat_idle, i_clk, i_rst_n, r_st == S_FAULT, o_valid && !busy, "fault not reported")
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the block and page address translation unit.
module tb_top;
    import mmu_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 300;

    typedef struct packed {
        logic [31:0] pa;
        logic        ok;
        logic [1:0]  fk;
        logic [1:0]  ek;
        logic [31:0] fa;
        logic [31:0] fs;
    } t_xlate_result;

    class xlate_scoreboard;
        logic [31:0]   base_mask;
        logic [31:0]   bat_up[BAT_N];
        logic [31:0]   bat_lo[BAT_N];
        logic [31:0]   segs[16];
        logic [63:0]   ptes[TABLE_ENTRIES];
        t_xlate_result awaited[$];
        int            errors;

        function new();
            base_mask = '0;
            errors = 0;
            foreach (bat_up[i]) begin
                bat_up[i] = '0;
                bat_lo[i] = '0;
            end
            foreach (segs[i]) segs[i] = '0;
            foreach (ptes[i]) ptes[i] = '0;
        endfunction

        function logic blocked(logic [1:0] pp, logic store);
            return store ? (pp != 2'd2) : (pp == 2'd0);
        endfunction

        function t_xlate_result translate(logic [31:0] ea, logic [2:0] flags, logic user);
            t_xlate_result r;
            logic          code, store, quiet, fault, found;
            logic [31:0]   up, lo, bl, msk, sr, vsid, hash, target, pteg, lw;
            logic [63:0]   pte;
            logic [31:0]   status;
            logic [1:0]    kind;
            int            side;
            code = flags[0];
            store = flags[1];
            quiet = flags[2];
            side = code ? 0 : BAT_PER_SIDE;
            status = ST_PROT;
            kind = FK_PROT;
            fault = 1'b0;
            found = 1'b0;
            r = '0;
            for (int i = 0; i < BAT_PER_SIDE && !found; i++) begin
                up = bat_up[side + i];
                lo = bat_lo[side + i];
                if (user ? up[0] : up[1]) begin
                    bl = up & 32'h0000_1FFC;
                    msk = (~bl << 15) & 32'hFFFE_0000;
                    if ((ea & msk) == (up & 32'hFFFE_0000)) begin
                        found = 1'b1;
                        if (blocked(lo[1:0], store)) begin
                            fault = 1'b1;
                        end else begin
                            r.pa = (lo & 32'hFFFE_0000) | (ea & ((bl << 15) | 32'h0001_FFFF));
                            r.ok = 1'b1;
                            return r;
                        end
                    end
                end
            end
            if (!fault) begin
                sr = segs[ea[31:28]];
                if (sr[31]) begin
                    r.fk = FK_DS;
                    return r;
                end
                if (code && sr[28]) begin
                    fault = 1'b1;
                end else begin
                    vsid = sr & 32'h00FF_FFFF;
                    hash = (vsid & 32'h0007_FFFF) ^ ((ea >> 12) & 32'hFFFF);
                    target = (vsid << 7) | ((ea >> 22) & 32'h3F) | 32'h8000_0000;
                    for (int h = 0; h < 2 && !fault; h++) begin
                        pteg = (base_mask & 32'hFFFF_0000)
                            | (((base_mask & 32'h01FF) & (hash >> 10)) << 16)
                            | ((hash & 32'h03FF) << 6);
                        for (int i = 0; i < ENTRIES_PER_GROUP; i++) begin
                            pte = ptes[((pteg >> 3) + i) % TABLE_ENTRIES];
                            if (pte[63:32] == target) begin
                                lw = pte[31:0];
                                if (blocked(lw[1:0], store)) begin
                                    fault = 1'b1;
                                    break;
                                end
                                r.pa = (lw & 32'hFFFF_F000) | (ea & 32'hFFF);
                                r.ok = 1'b1;
                                return r;
                            end
                        end
                        hash ^= 32'h7FFFF;
                        target ^= 32'h40;
                    end
                    if (!fault) begin
                        status = ST_PAGE;
                        kind = FK_PAGE;
                    end
                end
            end
            r.fk = kind;
            if (!quiet) begin
                if (code) begin
                    r.ek = EK_ISI;
                end else begin
                    r.ek = EK_DSI;
                    r.fa = ea;
                    r.fs = store ? (status | ST_STORE) : status;
                end
            end
            return r;
        endfunction

        function void note_item(logic [2:0] op, logic [11:0] idx, logic [31:0] ea,
                                logic [63:0] wd, logic [2:0] flags, logic user);
            t_xlate_result r;
            r = '0;
            r.ok = 1'b1;
            case (op)
                OP_XLATE: r = translate(ea, flags, user);
                OP_BATU: if (idx < BAT_N) bat_up[idx] = wd[31:0];
                OP_BATL: if (idx < BAT_N) bat_lo[idx] = wd[31:0];
                OP_SEG: if (idx < 16) segs[idx] = wd[31:0];
                OP_PTE: if (idx < TABLE_ENTRIES) ptes[idx] = wd;
                default: r = '0;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_beat(t_xlate_result got);
            t_xlate_result want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch pa %h/%h ok %b/%b fk %0d/%0d ek %0d/%0d fa %h/%h fs %h/%h",
                         $time, want.pa, got.pa, want.ok, got.ok, want.fk, got.fk,
                         want.ek, got.ek, want.fa, got.fa, want.fs, got.fs);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [11:0] i_table_index;
    logic [31:0] i_effective_address;
    logic [63:0] i_write_data;
    logic [2:0]  i_access_flags;
    logic        i_problem_state;
    logic        o_valid;
    logic [31:0] o_physical_address;
    logic        o_translated;
    logic [1:0]  o_fault_kind;
    logic [1:0]  o_exception_kind;
    logic [31:0] o_fault_address;
    logic [31:0] o_fault_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    xlate_scoreboard sb;
    int              cycles;
    int              idle_pct;
    int              sent;

    mmu_block_and_page_translation u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_beat({o_physical_address, o_translated, o_fault_kind,
                           o_exception_kind, o_fault_address, o_fault_status});
    end

    task automatic send(logic [2:0] op, logic [11:0] idx, logic [31:0] ea,
                        logic [63:0] wd, logic [2:0] flags, logic user);
        int gap;
        @(negedge i_clk);
        start = 1'b1;
        i_opcode = op;
        i_table_index = idx;
        i_effective_address = ea;
        i_write_data = wd;
        i_access_flags = flags;
        i_problem_state = user;
        do @(posedge i_clk); while (busy);
        sb.note_item(op, idx, ea, wd, flags, user);
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(6, 1);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.awaited.size() != 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_base_mask(logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = '0;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.base_mask = value;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic logic [11:0] group_slot(logic [31:0] vsid, logic [31:0] ea,
                                               logic secondary);
        logic [31:0] hash;
        hash = (vsid & 32'h0007_FFFF) ^ ((ea >> 12) & 32'hFFFF);
        if (secondary) hash ^= 32'h7FFFF;
        return {hash[8:0], 3'b000};
    endfunction

    task automatic page_sequence();
        logic [31:0] sr, ea, target;
        logic        secondary;
        ea = $urandom;
        sr = {4'b0000, 4'($urandom), 24'($urandom)};
        if ($urandom_range(9) == 0) sr[31] = 1'b1;
        if ($urandom_range(9) == 0) sr[28] = 1'b1;
        secondary = $urandom_range(1);
        target = ({8'h00, sr[23:0]} << 7) | ((ea >> 22) & 32'h3F) | 32'h8000_0000;
        if (secondary) target ^= 32'h40;
        send(OP_SEG, 12'(ea[31:28]), '0, {32'($urandom), sr}, '0, 1'b0);
        send(OP_PTE, group_slot({8'h00, sr[23:0]}, ea, secondary) + 12'($urandom_range(7)),
             '0, {target, 32'($urandom)}, '0, 1'b0);
        repeat ($urandom_range(2, 1))
            send(OP_XLATE, 12'($urandom), {ea[31:12], 12'($urandom)}, {$urandom, $urandom},
                 3'($urandom), 1'($urandom));
    endtask

    task automatic bat_sequence();
        logic [31:0] up, ea;
        logic [11:0] idx;
        idx = 12'($urandom_range(BAT_N - 1));
        ea = $urandom;
        up = {ea[31:17], 4'($urandom), 11'($urandom), 2'($urandom)};
        send(OP_BATU, idx, '0, {$urandom, up}, '0, 1'b0);
        send(OP_BATL, idx, '0, {$urandom, $urandom}, '0, 1'b0);
        send(OP_XLATE, '0, ea, '0,
             {1'($urandom), 1'($urandom), idx < BAT_PER_SIDE}, 1'($urandom));
    endtask

    task automatic run_phase(int pct);
        int start_count;
        idle_pct = pct;
        start_count = sent;
        while (sent - start_count < PHASE_ITEMS) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: page_sequence();
                5, 6: bat_sequence();
                default: send(3'($urandom), 12'($urandom), $urandom, {$urandom, $urandom},
                              3'($urandom), 1'($urandom));
            endcase
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        idle_pct = 0;
        sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = '0;
        i_table_index = '0;
        i_effective_address = '0;
        i_write_data = '0;
        i_access_flags = '0;
        i_problem_state = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (busy) @(posedge i_clk);
        write_base_mask(32'h0000_0000);

        // Short directed pass over the corner cases.
        send(OP_XLATE, '0, 32'h0000_0000, '0, 3'b000, 1'b0);
        send(OP_XLATE, '0, 32'hFFFF_FFFF, '0, 3'b010, 1'b1);
        send(OP_XLATE, '0, 32'h1234_5678, '0, 3'b001, 1'b0);
        send(OP_XLATE, '0, 32'h1234_5678, '0, 3'b111, 1'b0);
        send(3'd5, 12'hFFF, 32'hFFFF_FFFF, '1, 3'b111, 1'b1);
        send(3'd7, '0, '0, '0, '0, 1'b0);
        send(OP_BATU, 12'd8, '0, '1, '0, 1'b0);
        send(OP_BATL, 12'hFFF, '0, '1, '0, 1'b0);
        send(OP_SEG, 12'd16, '0, '1, '0, 1'b0);
        send(OP_PTE, 12'hFFF, '0, '1, '0, 1'b0);
        send(OP_SEG, 12'd15, '0, 64'h0000_0000_8000_0000, '0, 1'b0);
        send(OP_XLATE, '0, 32'hF000_0000, '0, 3'b000, 1'b0);
        send(OP_SEG, 12'd1, '0, 64'h0000_0000_1000_0001, '0, 1'b0);
        send(OP_XLATE, '0, 32'h1000_0000, '0, 3'b001, 1'b0);
        send(OP_BATU, 12'd4, '0, 64'h0000_0000_2000_1FFF, '0, 1'b0);
        send(OP_BATL, 12'd4, '0, 64'h0000_0000_4000_0001, '0, 1'b0);
        send(OP_XLATE, '0, 32'h2ABC_DEF0, '0, 3'b000, 1'b1);
        send(OP_XLATE, '0, 32'h2ABC_DEF0, '0, 3'b010, 1'b0);
        send(OP_BATL, 12'd4, '0, 64'h0000_0000_4000_0000, '0, 1'b0);
        send(OP_XLATE, '0, 32'h2ABC_DEF0, '0, 3'b000, 1'b0);
        drain();

        write_base_mask(32'hFFFF_FFFF);
        run_phase(0);
        drain();
        write_base_mask($urandom);
        run_phase(66);
        drain();
        write_base_mask(32'h1234_01FF);
        run_phase(0);
        drain();
        write_base_mask(32'h0000_0000);
        run_phase(30);
        drain();

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/mmu_pkg.sv
hdl/mmu_block_and_page_translation.sv
sim/tb_top.sv
